### src/otrm_pkg.sv
// ----------------------------------------------------------------------------
// otrm_pkg: shared definitions for the opacity table resample/merge unit
// Table geometry, codes for item kinds and config registers, divider
// request/response structs and small Q1.15 helper functions.
// ----------------------------------------------------------------------------
package otrm_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 7;                    // width of count registers
    localparam int VAL_W       = 16;                   // Q1.15 value width
    localparam int FRAC_W      = 15;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int DIV_W       = 2 * ADDR_W + FRAC_W;  // (num << 15) dividend width
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int TDATA_W     = 24;

    localparam logic [VAL_W-1:0] Q_ONE = VAL_W'(32768);

    // Item kinds carried on tuser
    typedef enum logic [1:0] {
        KIND_COLOR   = 2'd0,
        KIND_OPACITY = 2'd1,
        KIND_COMPUTE = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_COLOR_COUNT   = 2'd0,
        CFG_OPACITY_COUNT = 2'd1,
        CFG_ALPHA_SCALE   = 2'd2
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_NUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ADDR_K,
        ST_RD_A,
        ST_RD_B,
        ST_LERP,
        ST_MERGE,
        ST_EMIT
    } state_t;

    // Divider handshake
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [ADDR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Saturate a 17-bit Q1.15 value at 1.0
    function automatic logic [VAL_W-1:0] q_sat(input logic [VAL_W:0] v);
        logic [VAL_W-1:0] r;
        if (v > {1'b0, Q_ONE})
            r = Q_ONE;
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

    // Clamp a count register to 1..TABLE_DEPTH
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0)
            r = CNT_W'(1);
        else if (c > CNT_W'(TABLE_DEPTH))
            r = CNT_W'(TABLE_DEPTH);
        else
            r = c;
        return r;
    endfunction

endpackage

### src/otrm_table_ram.sv
// ----------------------------------------------------------------------------
// otrm_table_ram: one Q1.15 table
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module otrm_table_ram
    import otrm_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [VAL_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [VAL_W-1:0]  rd_data
);

    logic [VAL_W-1:0] mem [TABLE_DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/otrm_divider.sv
// ----------------------------------------------------------------------------
// otrm_divider: restoring shift-subtract divider
// One quotient bit per cycle, one step per dividend bit; done pulses in the
// cycle after the last step, with the quotient held until the next start.
// ----------------------------------------------------------------------------
module otrm_divider
    import otrm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     quo_reg;
    logic [ADDR_W-1:0]    rem_reg;
    logic [ADDR_W-1:0]    den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [ADDR_W:0]      shifted;
    logic [ADDR_W+1:0]    trial;
    logic                 q_bit;

    // One trial subtraction
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign q_bit   = ~trial[ADDR_W+1];

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], q_bit};
            rem_reg <= q_bit ? trial[ADDR_W-1:0] : shifted[ADDR_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### src/opacity_table_resample_merge_unit.sv
// ----------------------------------------------------------------------------
// opacity_table_resample_merge_unit: opacity table resample and merge
// Loads color alpha and opacity tables and emits their merged resampling.
// ----------------------------------------------------------------------------
// A load word (tuser kind 0 color alpha, 1 opacity) writes one table entry;
// color alphas are scaled by alpha_scale on the way in. A color alpha load
// uses ST_LD_MUL and ST_LD_WR, an opacity load ST_LD_WR only, s_tready low
// meanwhile. A compute word (kind 2) resamples both tables by linear
// interpolation onto n = max(color_count, opacity_count) points and sends n
// output words, tlast on the final one. Each table's sample position goes
// through a 27-step shift-subtract divider, used twice per sample when n > 1,
// and one shared 16x16 multiplier does all products. The output word sits in
// a register, so a new input word is taken while the last result still waits.
// Kind 3 is dropped. Config writes are taken in any cycle but must only be
// made while the block is idle; alpha_scale affects later loads only. Table
// entries are undefined until written.
// ----------------------------------------------------------------------------
module opacity_table_resample_merge_unit
    import otrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [5:0] entry_index, [21:6] entry_value
    input  logic [1:0]         s_tuser,   // [1:0] kind
    // output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [5:0] out_index, [21:6] out_opacity
    output logic               m_tlast,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [VAL_W-1:0]   cfg_data
);

    // Configuration registers
    logic [CNT_W-1:0]  color_count_reg;
    logic [CNT_W-1:0]  opacity_count_reg;
    logic [VAL_W-1:0]  alpha_scale_reg;

    // Sequencer state
    state_t            state_reg, state_next;
    logic              tbl_reg, tbl_next;          // 0 color, 1 opacity
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] den_reg, den_next;
    logic [ADDR_W-1:0] cm1_c_reg, cm1_c_next;
    logic [ADDR_W-1:0] cm1_o_reg, cm1_o_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [FRAC_W-1:0] f_reg, f_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0]  ca_reg, ca_next;
    logic [VAL_W-1:0]  op_reg, op_next;
    logic              ld_color_reg, ld_color_next;
    logic [ADDR_W-1:0] ld_idx_reg, ld_idx_next;
    logic [VAL_W-1:0]  ld_val_reg, ld_val_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_index_reg, m_index_next;
    logic [VAL_W-1:0]  m_opac_reg, m_opac_next;
    logic              m_last_reg, m_last_next;

    // Shared multiplier
    logic [VAL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;

    // Table ports
    logic              wr_color, wr_opac;
    logic [VAL_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W-1:0]  rd_color, rd_opac, rd_sel;

    // Divider
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // Misc combinational
    logic              s_accept;
    logic [ADDR_W-1:0] cm1;
    logic [ADDR_W-1:0] j_addr;
    logic [PROD_W-1:0] lerp_sum;
    logic [VAL_W-1:0]  lerp_val;
    logic [CNT_W-1:0]  nc, no, n_max;
    logic [VAL_W-1:0]  scale_sat;
    logic              is_last;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign mul_p     = mul_a * mul_b;
    assign cm1       = tbl_reg ? cm1_o_reg : cm1_c_reg;
    assign j_addr    = (k_reg == cm1) ? cm1 : k_reg + ADDR_W'(1);
    assign rd_sel    = tbl_reg ? rd_opac : rd_color;
    assign lerp_sum  = acc_reg + prod_reg;
    assign lerp_val  = q_sat(lerp_sum[PROD_W-1:FRAC_W]);
    assign nc        = clamp_count(color_count_reg);
    assign no        = clamp_count(opacity_count_reg);
    assign n_max     = (nc > no) ? nc : no;
    assign scale_sat = q_sat({1'b0, alpha_scale_reg});
    assign is_last   = (i_reg == den_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_count_reg   <= CNT_W'(1);
            opacity_count_reg <= CNT_W'(1);
            alpha_scale_reg   <= Q_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COLOR_COUNT:   color_count_reg   <= cfg_data[CNT_W-1:0];
                CFG_OPACITY_COUNT: opacity_count_reg <= cfg_data[CNT_W-1:0];
                CFG_ALPHA_SCALE:   alpha_scale_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Tables
    otrm_table_ram u_color_ram (
        .clk     (clk),
        .wr_en   (wr_color),
        .wr_addr (ld_idx_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_color)
    );

    otrm_table_ram u_opac_ram (
        .clk     (clk),
        .wr_en   (wr_opac),
        .wr_addr (ld_idx_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_opac)
    );

    // Position divider
    otrm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next    = state_reg;
        tbl_next      = tbl_reg;
        i_next        = i_reg;
        den_next      = den_reg;
        cm1_c_next    = cm1_c_reg;
        cm1_o_next    = cm1_o_reg;
        k_next        = k_reg;
        f_next        = f_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        ca_next       = ca_reg;
        op_next       = op_reg;
        ld_color_next = ld_color_reg;
        ld_idx_next   = ld_idx_reg;
        ld_val_next   = ld_val_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_index_next  = m_index_reg;
        m_opac_next   = m_opac_reg;
        m_last_next   = m_last_reg;
        mul_a         = '0;
        mul_b         = '0;
        wr_color      = 1'b0;
        wr_opac       = 1'b0;
        wr_data       = ld_val_reg;
        rd_addr       = k_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {prod_reg[2*ADDR_W-1:0], {FRAC_W{1'b0}}};
        div_req.divisor  = den_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    ld_idx_next = s_tdata[ADDR_W-1:0];
                    ld_val_next = q_sat({1'b0, s_tdata[ADDR_W+VAL_W-1:ADDR_W]});
                    case (s_tuser)
                        KIND_COLOR:
                        begin
                            ld_color_next = 1'b1;
                            state_next    = ST_LD_MUL;
                        end
                        KIND_OPACITY:
                        begin
                            ld_color_next = 1'b0;
                            state_next    = ST_LD_WR;
                        end
                        KIND_COMPUTE:
                        begin
                            cm1_c_next = ADDR_W'(nc - CNT_W'(1));
                            cm1_o_next = ADDR_W'(no - CNT_W'(1));
                            den_next   = ADDR_W'(n_max - CNT_W'(1));
                            i_next     = '0;
                            tbl_next   = 1'b0;
                            state_next = ST_NUM;
                        end
                        default: ;
                    endcase
                end
            end

            // color alpha scaling
            ST_LD_MUL:
            begin
                mul_a      = ld_val_reg;
                mul_b      = scale_sat;
                prod_next  = mul_p;
                state_next = ST_LD_WR;
            end

            ST_LD_WR:
            begin
                wr_color   = ld_color_reg;
                wr_opac    = !ld_color_reg;
                wr_data    = ld_color_reg ? q_sat(prod_reg[PROD_W-1:FRAC_W]) : ld_val_reg;
                state_next = ST_IDLE;
            end

            // numerator i*(c-1)
            ST_NUM:
            begin
                mul_a      = {{(VAL_W-ADDR_W){1'b0}}, i_reg};
                mul_b      = {{(VAL_W-ADDR_W){1'b0}}, cm1};
                prod_next  = mul_p;
                state_next = ST_DIV_GO;
            end

            // single point: position is zero; else start the divider
            ST_DIV_GO:
            begin
                if (den_reg == '0)
                begin
                    k_next     = '0;
                    f_next     = '0;
                    state_next = ST_ADDR_K;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end

            // quotient holds {k, f}
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    k_next     = div_rsp.quotient[FRAC_W+ADDR_W-1:FRAC_W];
                    f_next     = div_rsp.quotient[FRAC_W-1:0];
                    state_next = ST_ADDR_K;
                end
            end

            ST_ADDR_K:
            begin
                rd_addr    = k_reg;
                state_next = ST_RD_A;
            end

            // a*(1-f), read neighbor
            ST_RD_A:
            begin
                rd_addr    = j_addr;
                mul_a      = rd_sel;
                mul_b      = Q_ONE - {1'b0, f_reg};
                prod_next  = mul_p;
                state_next = ST_RD_B;
            end

            // b*f
            ST_RD_B:
            begin
                mul_a      = rd_sel;
                mul_b      = {1'b0, f_reg};
                prod_next  = mul_p;
                acc_next   = prod_reg;
                state_next = ST_LERP;
            end

            ST_LERP:
            begin
                if (!tbl_reg)
                begin
                    ca_next    = lerp_val;
                    tbl_next   = 1'b1;
                    state_next = ST_NUM;
                end
                else
                begin
                    op_next    = lerp_val;
                    state_next = ST_MERGE;
                end
            end

            ST_MERGE:
            begin
                mul_a      = ca_reg;
                mul_b      = op_reg;
                prod_next  = mul_p;
                state_next = ST_EMIT;
            end

            // hand the sample to the output register
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_index_next = i_reg;
                    m_opac_next  = q_sat(prod_reg[PROD_W-1:FRAC_W]);
                    m_last_next  = is_last;
                    tbl_next     = 1'b0;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + ADDR_W'(1);
                        state_next = ST_NUM;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tbl_reg     <= 1'b0;
            i_reg       <= '0;
            den_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tbl_reg     <= tbl_next;
            i_reg       <= i_next;
            den_reg     <= den_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cm1_c_reg    <= cm1_c_next;
        cm1_o_reg    <= cm1_o_next;
        k_reg        <= k_next;
        f_reg        <= f_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        ca_reg       <= ca_next;
        op_reg       <= op_next;
        ld_color_reg <= ld_color_next;
        ld_idx_reg   <= ld_idx_next;
        ld_val_reg   <= ld_val_next;
        m_index_reg  <= m_index_next;
        m_opac_reg   <= m_opac_next;
        m_last_reg   <= m_last_next;
    end

    // Output word
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W-ADDR_W-VAL_W){1'b0}}, m_opac_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

endmodule
